[rtl/acec_pkg.sv]
// Shared types and constants for the aperture cut-edge classifier.
// Used by acec_ctrl, acec_datapath and aperture_cut_edge_classifier; no dependencies.
package acec_pkg;

    // Field widths fixed by the item and result formats.
    localparam int NODE_W     = 10;
    localparam int EDGE_W     = 12;
    localparam int NCOUNT_W   = 11;
    localparam int ECOUNT_W   = 13;
    localparam int TOTAL_W    = 13;
    localparam int STATUS_W   = 3;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Defaults for the top-level parameters.
    localparam int ACEC_MAX_NODES  = 1024;
    localparam int ACEC_MAX_EDGES  = 4096;
    localparam int ACEC_COUNT_BITS = 13;

    // Register reset values.
    localparam logic [NCOUNT_W-1:0] CLOSED_NODES_RST = NCOUNT_W'(1024);
    localparam logic [NCOUNT_W-1:0] OPEN_NODES_RST   = NCOUNT_W'(1024);
    localparam logic [ECOUNT_W-1:0] EDGES_RST        = ECOUNT_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOSED_NODES = 2'd0,
        REG_OPEN_NODES   = 2'd1,
        REG_EDGES        = 2'd2
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_MAP_RANGE  = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_EDGE_RANGE = 3'd3,
        ST_END_RANGE  = 3'd4
    } status_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_INTERNAL  = 2'd0,
        CLS_PERIMETER = 2'd1,
        CLS_CUT       = 2'd2
    } edge_class_t;

    typedef enum logic {
        REQ_MAP  = 1'b0,
        REQ_EDGE = 1'b1
    } req_t;

    // One entry of the boundary map.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] target;
    } map_entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic execute;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
    } ctl_stat_t;

endpackage

[rtl/acec_ctrl.sv]
// Sequencing controller for the aperture cut-edge classifier.
// Depends on acec_pkg for the command and status structs.
module acec_ctrl
    import acec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign cmd.clear_step = (state_reg == S_CLEAR);
    assign cmd.capture    = (state_reg == S_IDLE) && start;
    assign cmd.execute    = (state_reg == S_EXEC);
    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;

    // An accepted item is executed in the very next cycle.
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("accepted item was not executed in the next cycle");

    // Every executed item raises the done strobe in the following cycle.
    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> done)
        else $error("executed item produced no done strobe");

    // The strobe never fires without an execute cycle before it.
    a_done_has_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.execute))
        else $error("done strobe without an executed item");

endmodule

[rtl/acec_datapath.sv]
// Datapath of the aperture cut-edge classifier: boundary map memory, range
// checks, classification, class counters and configuration registers. Uses acec_pkg.
module acec_datapath
    import acec_pkg::*;
#(
    parameter int MAX_NODES  = ACEC_MAX_NODES,
    parameter int MAX_EDGES  = ACEC_MAX_EDGES,
    parameter int COUNT_BITS = ACEC_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_cmd_t              cmd,
    output ctl_stat_t             stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_type,
    input  logic [NODE_W-1:0]     map_closed_node,
    input  logic [NODE_W-1:0]     map_open_node,
    input  logic [EDGE_W-1:0]     edge_index,
    input  logic [NODE_W-1:0]     end_a,
    input  logic [NODE_W-1:0]     end_b,
    output logic [STATUS_W-1:0]   status,
    output logic [CLASS_W-1:0]    edge_class,
    output logic [NODE_W-1:0]     cut_open_node,
    output logic                  sign_negative,
    output logic [TOTAL_W-1:0]    perimeter_total,
    output logic [TOTAL_W-1:0]    cut_total,
    output logic [TOTAL_W-1:0]    internal_total
);

    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [NODE_AW-1:0] LAST_ADDR = NODE_AW'(MAX_NODES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Configuration registers.
    logic [NCOUNT_W-1:0] closed_nodes_reg;
    logic [NCOUNT_W-1:0] open_nodes_reg;
    logic [ECOUNT_W-1:0] edges_reg;

    // Captured item.
    logic              req_reg;
    logic [NODE_W-1:0] mc_reg;
    logic [NODE_W-1:0] mo_reg;
    logic [EDGE_W-1:0] ei_reg;
    logic [NODE_W-1:0] ea_reg;
    logic [NODE_W-1:0] eb_reg;

    // Boundary map and its registered read ports.
    map_entry_t map_mem [MAX_NODES];
    map_entry_t rd_a_reg;
    map_entry_t rd_b_reg;
    logic [NODE_AW-1:0] rd_addr_a;
    logic [NODE_AW-1:0] rd_addr_b;
    logic [NODE_AW-1:0] wr_addr;
    map_entry_t         wr_data;
    logic               mem_we;
    logic [NODE_AW-1:0] clear_addr_reg;

    // Class counters.
    logic [COUNT_BITS-1:0] perim_cnt_reg;
    logic [COUNT_BITS-1:0] cut_cnt_reg;
    logic [COUNT_BITS-1:0] int_cnt_reg;

    // Result registers.
    status_t           status_reg;
    edge_class_t       class_reg;
    logic [NODE_W-1:0] cut_node_reg;
    logic              neg_reg;

    status_t           status_next;
    edge_class_t       class_next;
    logic [NODE_W-1:0] cut_node_next;
    logic              neg_next;
    logic              map_write;
    logic              inc_perim;
    logic              inc_cut;
    logic              inc_int;
    logic              map_bad;
    logic              edge_bad;
    logic              ends_bad;

    function automatic logic node_ok(input logic [NODE_W-1:0] n,
                                     input logic [NCOUNT_W-1:0] bound);
        node_ok = ({1'b0, n} < bound) && (32'(n) < 32'(MAX_NODES));
    endfunction

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_nodes_reg <= CLOSED_NODES_RST;
            open_nodes_reg   <= OPEN_NODES_RST;
            edges_reg        <= EDGES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLOSED_NODES: closed_nodes_reg <= cfg_data[NCOUNT_W-1:0];
                REG_OPEN_NODES:   open_nodes_reg   <= cfg_data[NCOUNT_W-1:0];
                REG_EDGES:        edges_reg        <= cfg_data[ECOUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            mc_reg  <= map_closed_node;
            mo_reg  <= map_open_node;
            ei_reg  <= edge_index;
            ea_reg  <= end_a;
            eb_reg  <= end_b;
        end
    end

    // Port A looks up the closed node of a mapping or endpoint a, port B endpoint b.
    assign rd_addr_a = (req_type == REQ_EDGE) ? NODE_AW'(end_a) : NODE_AW'(map_closed_node);
    assign rd_addr_b = NODE_AW'(end_b);

    assign mem_we  = cmd.clear_step || (cmd.execute && map_write);
    assign wr_addr = cmd.clear_step ? clear_addr_reg : NODE_AW'(mc_reg);
    assign wr_data = cmd.clear_step ? map_entry_t'('0) : map_entry_t'({1'b1, mo_reg});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (cmd.capture)
        begin
            rd_a_reg <= map_mem[rd_addr_a];
            rd_b_reg <= map_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_addr_reg <= clear_addr_reg + NODE_AW'(1);
        end
    end

    assign stat.clear_last = (clear_addr_reg == LAST_ADDR);

    // Checks and classification of the captured item.
    assign map_bad  = !node_ok(mc_reg, closed_nodes_reg) || ({1'b0, mo_reg} >= open_nodes_reg);
    assign edge_bad = ({1'b0, ei_reg} >= edges_reg) || (32'(ei_reg) >= 32'(MAX_EDGES));
    assign ends_bad = !node_ok(ea_reg, closed_nodes_reg) || !node_ok(eb_reg, closed_nodes_reg);

    always_comb
    begin
        status_next   = ST_OK;
        class_next    = CLS_INTERNAL;
        cut_node_next = '0;
        neg_next      = 1'b0;
        map_write     = 1'b0;
        inc_perim     = 1'b0;
        inc_cut       = 1'b0;
        inc_int       = 1'b0;
        if (req_reg == REQ_MAP)
        begin
            if (map_bad)
            begin
                status_next = ST_MAP_RANGE;
            end
            else if (rd_a_reg.valid)
            begin
                status_next = ST_DUPLICATE;
            end
            else
            begin
                map_write = 1'b1;
            end
        end
        else if (edge_bad)
        begin
            status_next = ST_EDGE_RANGE;
        end
        else if (ends_bad)
        begin
            status_next = ST_END_RANGE;
        end
        else if (rd_a_reg.valid && rd_b_reg.valid)
        begin
            class_next = CLS_PERIMETER;
            inc_perim  = 1'b1;
        end
        else if (!rd_a_reg.valid && !rd_b_reg.valid)
        begin
            class_next = CLS_INTERNAL;
            inc_int    = 1'b1;
        end
        else
        begin
            class_next = CLS_CUT;
            inc_cut    = 1'b1;
            if (rd_a_reg.valid)
            begin
                cut_node_next = rd_a_reg.target;
                neg_next      = 1'b1;
            end
            else
            begin
                cut_node_next = rd_b_reg.target;
            end
        end
    end

    // Counters saturate at all ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perim_cnt_reg <= '0;
            cut_cnt_reg   <= '0;
            int_cnt_reg   <= '0;
        end
        else if (cmd.execute)
        begin
            if (inc_perim && (perim_cnt_reg != '1))
            begin
                perim_cnt_reg <= perim_cnt_reg + COUNT_ONE;
            end
            if (inc_cut && (cut_cnt_reg != '1))
            begin
                cut_cnt_reg <= cut_cnt_reg + COUNT_ONE;
            end
            if (inc_int && (int_cnt_reg != '1))
            begin
                int_cnt_reg <= int_cnt_reg + COUNT_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg   <= status_next;
            class_reg    <= class_next;
            cut_node_reg <= cut_node_next;
            neg_reg      <= neg_next;
        end
    end

    assign status          = status_reg;
    assign edge_class      = class_reg;
    assign cut_open_node   = cut_node_reg;
    assign sign_negative   = neg_reg;
    assign perimeter_total = TOTAL_W'(perim_cnt_reg);
    assign cut_total       = TOTAL_W'(cut_cnt_reg);
    assign internal_total  = TOTAL_W'(int_cnt_reg);

    // A mapping is only ever stored over an entry that was read as free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && map_write) |-> !rd_a_reg.valid)
        else $error("mapping written over a valid entry");

    // The class counters never move backward.
    a_counts_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (perim_cnt_reg >= $past(perim_cnt_reg))
              && (cut_cnt_reg >= $past(cut_cnt_reg))
              && (int_cnt_reg >= $past(int_cnt_reg)))
        else $error("class counter decreased");

endmodule

[rtl/aperture_cut_edge_classifier.sv]
// Top level of the aperture cut-edge classifier.
// Instantiates acec_ctrl and acec_datapath; uses acec_pkg.
//
// Each accepted item, a mapping insert or an edge to classify, is handled in
// order: the cycle that ends at the accepting edge reads both map ports, and
// the following execute cycle checks, classifies, writes the map and updates
// the counters. Busy is high during the execute cycle, so no new item can be
// accepted until the last one has executed. The result is registered at the
// end of the execute cycle and driven with the done strobe for exactly one
// cycle. The receiver cannot hold a result off, so done must be taken when it
// is shown. After reset the block sweeps the boundary map to invalid, one
// entry per cycle, which keeps busy high until the last entry is cleared;
// configuration writes are taken at any time, and cfg_ready is always high.
// Configuration should only be written while no item is in flight. Bad items
// are flagged in status and change no state.
module aperture_cut_edge_classifier
    import acec_pkg::*;
#(
    parameter int MAX_NODES  = ACEC_MAX_NODES,
    parameter int MAX_EDGES  = ACEC_MAX_EDGES,
    parameter int COUNT_BITS = ACEC_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [NODE_W-1:0]     map_closed_node,
    input  logic [NODE_W-1:0]     map_open_node,
    input  logic [EDGE_W-1:0]     edge_index,
    input  logic [NODE_W-1:0]     end_a,
    input  logic [NODE_W-1:0]     end_b,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [CLASS_W-1:0]    edge_class,
    output logic [NODE_W-1:0]     cut_open_node,
    output logic                  sign_negative,
    output logic [TOTAL_W-1:0]    perimeter_total,
    output logic [TOTAL_W-1:0]    cut_total,
    output logic [TOTAL_W-1:0]    internal_total
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // The register file accepts a configuration beat in every cycle.
    assign cfg_ready = 1'b1;

    acec_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    acec_datapath #(
        .MAX_NODES  (MAX_NODES),
        .MAX_EDGES  (MAX_EDGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .map_closed_node (map_closed_node),
        .map_open_node   (map_open_node),
        .edge_index      (edge_index),
        .end_a           (end_a),
        .end_b           (end_b),
        .status          (status),
        .edge_class      (edge_class),
        .cut_open_node   (cut_open_node),
        .sign_negative   (sign_negative),
        .perimeter_total (perimeter_total),
        .cut_total       (cut_total),
        .internal_total  (internal_total)
    );

endmodule

[tb/sv/acec_class_checker.sv]
// Scoreboard for the aperture cut-edge classifier: watches the item, result and register channels.
// Keeps its own boundary map, class counters and bounds, and compares every result beat.
// Depends on acec_pkg for widths, status codes, class codes and register indexes.
module acec_class_checker
    import acec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  req_type,
    input  logic [NODE_W-1:0]     map_closed_node,
    input  logic [NODE_W-1:0]     map_open_node,
    input  logic [EDGE_W-1:0]     edge_index,
    input  logic [NODE_W-1:0]     end_a,
    input  logic [NODE_W-1:0]     end_b,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  done,
    input  logic [STATUS_W-1:0]   status,
    input  logic [CLASS_W-1:0]    edge_class,
    input  logic [NODE_W-1:0]     cut_open_node,
    input  logic                  sign_negative,
    input  logic [TOTAL_W-1:0]    perimeter_total,
    input  logic [TOTAL_W-1:0]    cut_total,
    input  logic [TOTAL_W-1:0]    internal_total,
    output int                    mismatch_count,
    output int                    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TOTAL_W-1:0] COUNT_CEIL =
        TOTAL_W'((64'd1 << ACEC_COUNT_BITS) - 64'd1);
    localparam int PRINT_CAP = 100;

    typedef struct {
        status_t             st;
        edge_class_t         cls;
        logic [NODE_W-1:0]   target_node;
        logic                neg;
        logic [TOTAL_W-1:0]  perimeter;
        logic [TOTAL_W-1:0]  cut;
        logic [TOTAL_W-1:0]  internal;
    } outcome_t;

    outcome_t expected_outcomes[$];

    logic                 node_mapped [ACEC_MAX_NODES];
    logic [NODE_W-1:0]    node_target [ACEC_MAX_NODES];
    logic [TOTAL_W-1:0]   perimeter_seen;
    logic [TOTAL_W-1:0]   cut_seen;
    logic [TOTAL_W-1:0]   internal_seen;
    logic [NCOUNT_W-1:0]  closed_bound;
    logic [NCOUNT_W-1:0]  open_bound;
    logic [ECOUNT_W-1:0]  edge_bound;
    int                   results_seen;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t: result %0d, %s: got %0d, expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] c);
        return (c < COUNT_CEIL) ? c + 1'b1 : c;
    endfunction

    function automatic bit node_in_range(input logic [NODE_W-1:0] n);
        return (n < closed_bound) && (n < ACEC_MAX_NODES);
    endfunction

    // Applies one item to the local map and counters and gives the result it must produce.
    task automatic classify_item(input req_t rt, input logic [NODE_W-1:0] mc,
                                 input logic [NODE_W-1:0] mo, input logic [EDGE_W-1:0] ei,
                                 input logic [NODE_W-1:0] ea, input logic [NODE_W-1:0] eb,
                                 output outcome_t o);
        logic a_on_rim;
        logic b_on_rim;
        o.st          = ST_OK;
        o.cls         = CLS_INTERNAL;
        o.target_node = '0;
        o.neg         = 1'b0;
        if (rt == REQ_MAP) begin
            if (!node_in_range(mc) || mo >= open_bound)
                o.st = ST_MAP_RANGE;
            else if (node_mapped[mc])
                o.st = ST_DUPLICATE;
            else begin
                node_mapped[mc] = 1'b1;
                node_target[mc] = mo;
            end
        end else begin
            if (ei >= edge_bound || ei >= ACEC_MAX_EDGES)
                o.st = ST_EDGE_RANGE;
            else if (!node_in_range(ea) || !node_in_range(eb))
                o.st = ST_END_RANGE;
            else begin
                a_on_rim = node_mapped[ea];
                b_on_rim = node_mapped[eb];
                if (a_on_rim && b_on_rim) begin
                    o.cls = CLS_PERIMETER;
                    perimeter_seen = bump(perimeter_seen);
                end else if (!a_on_rim && !b_on_rim) begin
                    internal_seen = bump(internal_seen);
                end else begin
                    o.cls = CLS_CUT;
                    cut_seen = bump(cut_seen);
                    // The sign is negative when the tail is the boundary endpoint.
                    o.neg         = a_on_rim;
                    o.target_node = a_on_rim ? node_target[ea] : node_target[eb];
                end
            end
        end
        o.perimeter = perimeter_seen;
        o.cut       = cut_seen;
        o.internal  = internal_seen;
    endtask

    // Reset is also taken on a clock edge, so the state is cleared even if no falling
    // edge of the reset is ever seen at time zero.
    always @(posedge clk or negedge rst_n) begin : watch
        outcome_t due;
        outcome_t fresh;
        if (!rst_n) begin
            for (int n = 0; n < ACEC_MAX_NODES; n++) begin
                node_mapped[n] = 1'b0;
                node_target[n] = '0;
            end
            perimeter_seen = '0;
            cut_seen       = '0;
            internal_seen  = '0;
            closed_bound   = CLOSED_NODES_RST;
            open_bound     = OPEN_NODES_RST;
            edge_bound     = EDGES_RST;
            results_seen   = 0;
            expected_outcomes.delete();
            pending_count <= 0;
        end else begin
            if (done === 1'b1) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", 1, 0);
                end else begin
                    due = expected_outcomes.pop_front();
                    if (status !== due.st)
                        report_mismatch("status", int'(status), int'(due.st));
                    if (edge_class !== due.cls)
                        report_mismatch("edge_class", int'(edge_class), int'(due.cls));
                    if (cut_open_node !== due.target_node)
                        report_mismatch("cut_open_node", int'(cut_open_node),
                                        int'(due.target_node));
                    if (sign_negative !== due.neg)
                        report_mismatch("sign_negative", int'(sign_negative), int'(due.neg));
                    if (perimeter_total !== due.perimeter)
                        report_mismatch("perimeter_total", int'(perimeter_total),
                                        int'(due.perimeter));
                    if (cut_total !== due.cut)
                        report_mismatch("cut_total", int'(cut_total), int'(due.cut));
                    if (internal_total !== due.internal)
                        report_mismatch("internal_total", int'(internal_total),
                                        int'(due.internal));
                end
                results_seen++;
            end
            if (start === 1'b1 && busy === 1'b0) begin
                classify_item(req_t'(req_type), map_closed_node, map_open_node, edge_index,
                              end_a, end_b, fresh);
                expected_outcomes.push_back(fresh);
            end
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
                case (cfg_index)
                    REG_CLOSED_NODES: closed_bound = cfg_data[NCOUNT_W-1:0];
                    REG_OPEN_NODES:   open_bound   = cfg_data[NCOUNT_W-1:0];
                    REG_EDGES:        edge_bound   = cfg_data[ECOUNT_W-1:0];
                    default:          ;
                endcase
            end
            pending_count <= expected_outcomes.size();
        end
    end

endmodule

[tb/sv/tb_aperture_cut_edge_classifier.sv]
// Top of the aperture cut-edge classifier testbench: clock, reset, stimulus and verdict.
// Instantiates aperture_cut_edge_classifier and acec_class_checker; uses acec_pkg.
module tb_aperture_cut_edge_classifier
    import acec_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Index that names no register; a write to it must leave every bound alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // The block sweeps its whole map after reset, so the watchdog has to sit well above
    // that sweep before it gives up on a quiet channel.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 450;
    localparam int SATURATE_LOOPS = 50;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  start           = 1'b0;
    logic                  req_type        = 1'b0;
    logic [NODE_W-1:0]     map_closed_node = '0;
    logic [NODE_W-1:0]     map_open_node   = '0;
    logic [EDGE_W-1:0]     edge_index      = '0;
    logic [NODE_W-1:0]     end_a           = '0;
    logic [NODE_W-1:0]     end_b           = '0;
    logic                  cfg_valid       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;

    logic                  busy;
    logic                  cfg_ready;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [CLASS_W-1:0]    edge_class;
    logic [NODE_W-1:0]     cut_open_node;
    logic                  sign_negative;
    logic [TOTAL_W-1:0]    perimeter_total;
    logic [TOTAL_W-1:0]    cut_total;
    logic [TOTAL_W-1:0]    internal_total;

    int mismatch_count;
    int pending_count;

    // Stimulus bookkeeping only: the bounds last written, the sender's idle rate, and
    // which closed nodes have ever been offered in a mapping beat.
    int cur_closed = 1024;
    int cur_open   = 1024;
    int cur_edges  = 4096;
    int idle_pct   = 0;
    bit map_sent [ACEC_MAX_NODES];
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    aperture_cut_edge_classifier u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .map_closed_node (map_closed_node),
        .map_open_node   (map_open_node),
        .edge_index      (edge_index),
        .end_a           (end_a),
        .end_b           (end_b),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status          (status),
        .edge_class      (edge_class),
        .cut_open_node   (cut_open_node),
        .sign_negative   (sign_negative),
        .perimeter_total (perimeter_total),
        .cut_total       (cut_total),
        .internal_total  (internal_total)
    );

    acec_class_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .map_closed_node (map_closed_node),
        .map_open_node   (map_open_node),
        .edge_index      (edge_index),
        .end_a           (end_a),
        .end_b           (end_b),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status          (status),
        .edge_class      (edge_class),
        .cut_open_node   (cut_open_node),
        .sign_negative   (sign_negative),
        .perimeter_total (perimeter_total),
        .cut_total       (cut_total),
        .internal_total  (internal_total),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count)
    );

    // The watchdog restarts whenever any beat moves on the item, result or register
    // channel. A hang anywhere shows up as a long quiet stretch.
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one item and holds it until the block takes it. The item is taken at the
    // first edge where busy is low, and the task returns at that edge, so a following
    // item can be presented back to back without start ever dropping.
    task automatic drive_item(input req_t rt, input logic [NODE_W-1:0] mc,
                              input logic [NODE_W-1:0] mo, input logic [EDGE_W-1:0] ei,
                              input logic [NODE_W-1:0] ea, input logic [NODE_W-1:0] eb);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start           <= 1'b1;
        req_type        <= rt;
        map_closed_node <= mc;
        map_open_node   <= mo;
        edge_index      <= ei;
        end_a           <= ea;
        end_b           <= eb;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (rt == REQ_MAP)
            map_sent[mc] = 1'b1;
    endtask

    // The fields that a beat does not use still carry random values, since the block
    // must ignore them.
    task automatic map_item(input int from_node, input int to_node);
        drive_item(REQ_MAP, NODE_W'(from_node), NODE_W'(to_node),
                   EDGE_W'($urandom_range(4095)), NODE_W'($urandom_range(1023)),
                   NODE_W'($urandom_range(1023)));
    endtask

    task automatic edge_item(input int edge_no, input int tail, input int head);
        drive_item(REQ_EDGE, NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)),
                   EDGE_W'(edge_no), NODE_W'(tail), NODE_W'(head));
    endtask

    // Drops start and waits until every result beat owed has come back. The first edge
    // is needed because the outstanding count is registered and lags an acceptance.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes are only made with the block drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CLOSED_NODES: cur_closed = value & 'h7FF;
            REG_OPEN_NODES:   cur_open   = value & 'h7FF;
            REG_EDGES:        cur_edges  = value & 'h1FFF;
            default:          ;
        endcase
    endtask

    task automatic write_bounds(input int closed_nodes, input int open_nodes,
                                input int edges);
        write_reg(REG_CLOSED_NODES, closed_nodes);
        write_reg(REG_OPEN_NODES, open_nodes);
        write_reg(REG_EDGES, edges);
    endtask

    // Range over which a well-formed index is drawn; a zero bound leaves the full field
    // range, which then exercises the range checks instead.
    function automatic int usable(input int bound, input int store_size);
        return (bound == 0 || bound > store_size) ? store_size : bound;
    endfunction

    // Mostly well-formed beats within the current bounds; about one in ten is noise
    // drawn over the full width of every field.
    task automatic random_item();
        int nodes;
        int opens;
        int edges;
        nodes = usable(cur_closed, ACEC_MAX_NODES);
        opens = usable(cur_open, ACEC_MAX_NODES);
        edges = usable(cur_edges, ACEC_MAX_EDGES);
        if ($urandom_range(99) < 10)
            drive_item(req_t'($urandom_range(1)), NODE_W'($urandom_range(1023)),
                       NODE_W'($urandom_range(1023)), EDGE_W'($urandom_range(4095)),
                       NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
        else if ($urandom_range(99) < 25)
            map_item($urandom_range(nodes - 1), $urandom_range(opens - 1));
        else
            edge_item($urandom_range(edges - 1), $urandom_range(nodes - 1),
                      $urandom_range(nodes - 1));
    endtask

    initial begin
        int spare_node;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Register writes are taken while the map sweep still holds busy high. The write
        // to the spare index must change nothing.
        write_bounds(1024, 1024, 4096);
        write_reg(REG_SPARE, 5);

        // Directed part. Map the extreme closed nodes to the extreme open nodes, then
        // try a duplicate with the same target and with a different one.
        map_item(0, 1023);
        map_item(1023, 0);
        map_item(0, 1023);
        map_item(0, 7);
        map_item(512, 'h155);
        // Edges of each class, with the cut found at the tail and at the head.
        edge_item(0, 0, 1023);
        edge_item(4095, 0, 1);
        edge_item(1, 1, 1023);
        edge_item(2, 1, 2);
        edge_item(3, 512, 512);
        edge_item(4, 513, 512);

        // A single closed node: node 1 is out of range, node 0 is a duplicate, and edges
        // that reach past node 0 fail the endpoint check.
        write_reg(REG_CLOSED_NODES, 1);
        map_item(1, 3);
        map_item(0, 3);
        edge_item(5, 0, 1);
        edge_item(6, 1023, 0);
        edge_item(7, 0, 0);

        // A single open node and a single edge, with the node bound above the store size.
        write_bounds(2047, 1, 1);
        map_item(2, 1);
        map_item(2, 0);
        edge_item(1, 1023, 0);
        edge_item(0, 2, 1023);
        write_reg(REG_EDGES, 8191);
        edge_item(4095, 2, 3);

        // Every bound at zero; the open bound gets there through the register width.
        write_bounds(0, 2048, 0);
        map_item(3, 0);
        edge_item(0, 0, 0);
        write_bounds(1024, 1024, 1);
        edge_item(0, 5, 5);

        // Random phases, each with its own bounds and sender idle rate.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_bounds(1024, 1024, 4096);
                    idle_pct = 0;
                end
                1: begin
                    write_bounds($urandom_range(64, 1024), $urandom_range(1, 1024),
                                 $urandom_range(1, 4096));
                    idle_pct = 51;
                end
                2: begin
                    write_bounds(2047, 2047, 8191);
                    idle_pct = 0;
                end
                default: begin
                    // Small bounds crowd the map, so duplicates and perimeter edges
                    // become common.
                    write_bounds($urandom_range(1, 40), $urandom_range(1, 40),
                                 $urandom_range(1, 64));
                    idle_pct = 16;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                // Now and then the sender holds off until every result is back.
                if ($urandom_range(199) == 0)
                    wait_drained();
                random_item();
            end
        end

        // Run the three classes back to back. A node that was never offered in a
        // mapping beat is surely off the boundary; nodes 0 and 1023 are on it.
        write_bounds(1024, 1024, 4096);
        idle_pct = 0;
        spare_node = 1022;
        for (int n = ACEC_MAX_NODES - 1; n >= 0; n--) begin
            if (!map_sent[n]) begin
                spare_node = n;
                break;
            end
        end
        repeat (SATURATE_LOOPS) begin
            edge_item($urandom_range(4095), spare_node, spare_node);
            edge_item($urandom_range(4095), 0, 1023);
            edge_item($urandom_range(4095), 0, spare_node);
        end
        idle_pct = 16;
        repeat (30) random_item();

        // Let the last results drain; the watchdog bounds this wait.
        wait_drained();
        if (mismatch_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
